// ===== rtl/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 byte-stream hasher.
// Used by every module under rtl/; depends on nothing.
`default_nettype none

package sha_pkg;

  // One input beat: a message byte and its framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } in_item_t;

  // One result beat: a digest word and its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One 512-bit block handed from front to back; word 0 sits in the top bits
  typedef struct packed {
    logic [511:0] words;
    logic         final_blk;
  } blk_t;

  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    F_COLLECT,
    F_PAD,
    F_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ROUND,
    B_ADD,
    B_OUT
  } back_state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha_front.sv =====
// Front end: packs message bytes into 512-bit blocks and appends padding.
// Depends on sha_pkg; feeds complete blocks into sha_bq.
`default_nettype none

module sha_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire sha_pkg::in_item_t in_data,
  output logic                  q_push,
  output sha_pkg::blk_t         q_data,
  input  wire logic             q_ready
);

  sha_pkg::front_state_t state_r, state_nxt;
  logic [60:0] cnt_r, cnt_nxt;
  logic [31:0] buf_r [16];
  logic [31:0] buf_nxt [16];
  logic [31:0] byte_words [16];
  logic [31:0] pad_words [16];
  logic [511:0] byte_flat, pad_flat, len_flat;
  logic [5:0]  pos;
  logic [3:0]  widx;
  logic [4:0]  sh;
  logic [63:0] bit_len;
  logic        accept;
  logic        fits;

  assign pos     = cnt_r[5:0];
  assign widx    = pos[5:2];
  assign sh      = {~pos[1:0], 3'b000};
  assign bit_len = {cnt_r, 3'b000};
  assign fits    = (pos < 6'd56);
  assign in_full = (state_r != sha_pkg::F_COLLECT) || !q_ready;
  assign accept  = in_push && !in_full;

  // Merge the incoming byte, and build the padded block
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (4'(i) == widx) begin
        byte_words[i] = (pos[1:0] == 2'd0) ? {in_data.data_byte, 24'h0}
                      : (buf_r[i] | ({24'h0, in_data.data_byte} << sh));
        pad_words[i]  = (pos[1:0] == 2'd0) ? 32'h8000_0000
                      : (buf_r[i] | (32'h0000_0080 << sh));
      end else if (4'(i) < widx) begin
        byte_words[i] = buf_r[i];
        pad_words[i]  = buf_r[i];
      end else begin
        byte_words[i] = buf_r[i];
        pad_words[i]  = '0;
      end
    end
    if (fits) begin
      pad_words[14] = bit_len[63:32];
      pad_words[15] = bit_len[31:0];
    end
    for (int i = 0; i < 16; i++) begin
      byte_flat[511-32*i -: 32] = byte_words[i];
      pad_flat[511-32*i -: 32]  = pad_words[i];
    end
    len_flat = {448'h0, bit_len};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha_pkg::F_COLLECT: begin
        if (accept && in_data.last_byte) state_nxt = sha_pkg::F_PAD;
      end
      sha_pkg::F_PAD: begin
        if (q_ready) state_nxt = fits ? sha_pkg::F_COLLECT : sha_pkg::F_LEN;
      end
      sha_pkg::F_LEN: begin
        if (q_ready) state_nxt = sha_pkg::F_COLLECT;
      end
      default: state_nxt = sha_pkg::F_COLLECT;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    q_push = 1'b0;
    q_data = '0;
    cnt_nxt = cnt_r;
    for (int i = 0; i < 16; i++) buf_nxt[i] = buf_r[i];
    case (state_r)
      sha_pkg::F_COLLECT: begin
        if (accept && in_data.byte_present) begin
          for (int i = 0; i < 16; i++) buf_nxt[i] = byte_words[i];
          cnt_nxt = cnt_r + 61'd1;
          if (pos == 6'd63) begin
            q_push = 1'b1;
            q_data.words = byte_flat;
          end
        end
      end
      sha_pkg::F_PAD: begin
        if (q_ready) begin
          q_push = 1'b1;
          q_data.words = pad_flat;
          q_data.final_blk = fits;
          if (fits) cnt_nxt = '0;
        end
      end
      sha_pkg::F_LEN: begin
        if (q_ready) begin
          q_push = 1'b1;
          q_data.words = len_flat;
          q_data.final_blk = 1'b1;
          cnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::F_COLLECT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold block words; no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) buf_r[i] <= buf_nxt[i];
  end

endmodule

`default_nettype wire

// ===== rtl/sha_bq.sv =====
// Short block queue between the front end and the compression engine.
// Depends on sha_pkg for the block type.
`default_nettype none

module sha_bq #(
  parameter int DEPTH = sha_pkg::QueueDepth
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sha_pkg::blk_t din,
  output logic               ready,
  input  wire logic          pop,
  output sha_pkg::blk_t      dout,
  output logic               nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sha_pkg::blk_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign ready    = (cnt_r != CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign do_push  = push && ready;
  assign do_pop   = pop && nonempty;
  assign dout     = mem_r[rp_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= inc(wp_r);
      if (do_pop)  rp_r <= inc(rp_r);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= din;
  end

endmodule

`default_nettype wire

// ===== rtl/sha_back.sv =====
// Back end: 64-round compression with a rolling schedule, chaining and digest output.
// Depends on sha_pkg; takes blocks from sha_bq.
`default_nettype none

module sha_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire sha_pkg::blk_t q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output sha_pkg::out_item_t out_data
);

  sha_pkg::back_state_t state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;
  logic        ovalid_r, ovalid_nxt;
  sha_pkg::out_item_t odata_r, odata_nxt;
  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] h_r [8];
  logic [31:0] h_nxt [8];
  logic [31:0] t1, t2, ch, mj, w_new;
  logic        out_load;

  assign out_empty = !ovalid_r;
  assign out_data  = odata_r;
  assign out_load  = !ovalid_r || out_pop;

  // Round function and schedule word
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    mj    = (v_r[0] & v_r[1]) ^ (v_r[1] & v_r[2]) ^ (v_r[2] & v_r[0]);
    t1    = v_r[7] + sha_pkg::big_sig1(v_r[4]) + ch + sha_pkg::round_k(rnd_r) + w_r[0];
    t2    = sha_pkg::big_sig0(v_r[0]) + mj;
    w_new = sha_pkg::sml_sig1(w_r[14]) + w_r[9] + sha_pkg::sml_sig0(w_r[1]) + w_r[0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha_pkg::B_IDLE:  if (q_valid) state_nxt = sha_pkg::B_ROUND;
      sha_pkg::B_ROUND: if (rnd_r == 6'd63) state_nxt = sha_pkg::B_ADD;
      sha_pkg::B_ADD:   state_nxt = fin_r ? sha_pkg::B_OUT : sha_pkg::B_IDLE;
      sha_pkg::B_OUT:   if (out_load && oidx_r == 3'd7) state_nxt = sha_pkg::B_IDLE;
      default:          state_nxt = sha_pkg::B_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    q_pop      = 1'b0;
    rnd_nxt    = rnd_r;
    oidx_nxt   = oidx_r;
    fin_nxt    = fin_r;
    ovalid_nxt = ovalid_r && !out_pop;
    odata_nxt  = odata_r;
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    for (int i = 0; i < 8; i++) begin
      v_nxt[i] = v_r[i];
      h_nxt[i] = h_r[i];
    end
    case (state_r)
      sha_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          rnd_nxt = '0;
          fin_nxt = q_data.final_blk;
          for (int i = 0; i < 16; i++) w_nxt[i] = q_data.words[511-32*i -: 32];
          for (int i = 0; i < 8; i++) v_nxt[i] = h_r[i];
        end
      end
      sha_pkg::B_ROUND: begin
        // Advance the working words and slide the schedule window
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
        w_nxt[15] = w_new;
        rnd_nxt = rnd_r + 6'd1;
      end
      sha_pkg::B_ADD: begin
        for (int i = 0; i < 8; i++) h_nxt[i] = h_r[i] + v_r[i];
        oidx_nxt = '0;
      end
      sha_pkg::B_OUT: begin
        if (out_load) begin
          ovalid_nxt            = 1'b1;
          odata_nxt.digest_word = h_r[oidx_r];
          odata_nxt.word_index  = oidx_r;
          odata_nxt.last_word   = (oidx_r == 3'd7);
          oidx_nxt              = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) h_nxt[i] = sha_pkg::init_hash(3'(i));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha_pkg::B_IDLE;
      ovalid_r <= 1'b0;
      rnd_r    <= '0;
      oidx_r   <= '0;
      fin_r    <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::init_hash(3'(i));
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      rnd_r    <= rnd_nxt;
      oidx_r   <= oidx_nxt;
      fin_r    <= fin_nxt;
      for (int i = 0; i < 8; i++) h_r[i] <= h_nxt[i];
    end
  end

  // Hold payload registers; no reset needed
  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
    for (int i = 0; i < 8; i++) v_r[i] <= v_nxt[i];
  end

endmodule

`default_nettype wire

// ===== rtl/sha256_byte_stream_hasher_unit.sv =====
// SHA-256 byte-stream hasher, top level.
// Usage:
//   Input channel: drive in_data and raise in_push; a beat is taken on a clock
//   edge with in_push high and in_full low. One byte per beat, most significant
//   byte of each word first. byte_present = 0 with last_byte = 1 ends a message
//   without a byte (the empty message); byte_present = 0 alone is ignored.
//   Result channel: eight beats per message, words A to H, while out_empty is
//   low; a beat is taken on an edge with out_pop high.
// Throughput: bytes are taken one per cycle while in_full is low; a block
//   passes through load, the rounds and the chaining add in the compression
//   engine, which paces input once the block queue fills. The two-block queue
//   sets how far the packer may run ahead of the round engine.
// After the last byte: the packer emits one or two padding blocks, each final
//   block is compressed, then the digest words leave one per cycle while the
//   receiver pops, behind any blocks still queued.
// Reset (rst_n low, synchronous): chaining words return to the initial hash,
//   byte count clears, queue and output register empty.
// A stalled receiver holds the current digest word; the engine waits and the
//   queue then back-pressures in_full.
`default_nettype none

module sha256_byte_stream_hasher_unit #(
  parameter int QDEPTH = sha_pkg::QueueDepth
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  output logic                    in_full,
  input  wire sha_pkg::in_item_t  in_data,
  output logic                    out_empty,
  input  wire logic               out_pop,
  output sha_pkg::out_item_t      out_data
);

  logic          f_push, q_ready, q_nonempty, b_pop;
  sha_pkg::blk_t f_blk, q_blk;

  // Pack and pad bytes into blocks
  sha_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (f_push),
    .q_data  (f_blk),
    .q_ready (q_ready)
  );

  // Decouple packer from round engine
  sha_bq #(
    .DEPTH (QDEPTH)
  ) u_bq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .din      (f_blk),
    .ready    (q_ready),
    .pop      (b_pop),
    .dout     (q_blk),
    .nonempty (q_nonempty)
  );

  // Compress blocks and emit the digest
  sha_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .q_data    (q_blk),
    .q_pop     (b_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/sha_checker.sv =====
// Port-level checks for the SHA-256 hasher, bound to the top level.
// Depends on sha_pkg for the channel types.
`default_nettype none

module sha_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_push,
  input wire logic               in_full,
  input wire sha_pkg::in_item_t  in_data,
  input wire logic               out_empty,
  input wire logic               out_pop,
  input wire sha_pkg::out_item_t out_data
);

  // Reset leaves no result waiting
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // The final digest word is flagged exactly at position H
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.last_word == (out_data.word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed while stalled");

  // Padding stalls input right after the end of a message
  a_pad_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && in_data.last_byte) |=> in_full)
    else $error("input taken during padding");

endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_data   (in_data),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the SHA-256 byte-stream hasher: drives messages, predicts digests.
// Depends on rtl/sha_pkg.sv and rtl/sha256_byte_stream_hasher_unit.sv.
`timescale 1ns / 100ps

class digest_scoreboard;
  logic [31:0] chain[8];
  logic [31:0] sched[16];
  logic [60:0] byte_count;
  sha_pkg::out_item_t pending_words[$];
  int errors;
  int digests_seen;

  function new();
    errors = 0;
    digests_seen = 0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h6a09e667; chain[1] = 32'hbb67ae85;
    chain[2] = 32'h3c6ef372; chain[3] = 32'ha54ff53a;
    chain[4] = 32'h510e527f; chain[5] = 32'h9b05688c;
    chain[6] = 32'h1f83d9ab; chain[7] = 32'h5be0cd19;
    byte_count = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function logic [31:0] kconst(int t);
    logic [31:0] k[64];
    k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
          32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
          32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
          32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
          32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
          32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
          32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
          32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
          32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
          32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
          32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
          32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
          32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  // Run 64 rounds over the current block and fold into the chain
  function void compress();
    logic [31:0] v[8];
    logic [31:0] w, x2, x15, t1, t2;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        w = sched[t];
      end else begin
        x2 = sched[(t - 2) & 15];
        x15 = sched[(t - 15) & 15];
        w = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + sched[(t - 7) & 15]
          + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + sched[t & 15];
        sched[t & 15] = w;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[1] & v[2]) ^ (v[2] & v[0]));
      for (int i = 7; i > 0; i--) v[i] = v[i - 1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function void place_byte(int pos, logic [7:0] b);
    if ((pos & 3) == 0) sched[pos >> 2] = {b, 24'h0};
    else sched[pos >> 2] |= 32'(b) << (24 - 8 * (pos & 3));
  endfunction

  // Note one accepted input beat
  function void note_input(sha_pkg::in_item_t it);
    int pos;
    logic [63:0] bits;
    sha_pkg::out_item_t o;
    if (it.byte_present) begin
      pos = int'(byte_count[5:0]);
      place_byte(pos, it.data_byte);
      byte_count++;
      if (pos == 63) compress();
    end
    if (!it.last_byte) return;
    pos = int'(byte_count[5:0]);
    place_byte(pos, 8'h80);
    for (int i = (pos >> 2) + 1; i < 16; i++) sched[i] = '0;
    if (pos >= 56) begin
      compress();
      for (int i = 0; i < 16; i++) sched[i] = '0;
    end
    bits = {byte_count, 3'b000};
    sched[14] = bits[63:32];
    sched[15] = bits[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain[i];
      o.word_index = 3'(i);
      o.last_word = (i == 7);
      pending_words = {pending_words, o};
    end
    restart();
  endfunction

  // Check one accepted result beat against the oldest expectation
  function void check_result(sha_pkg::out_item_t got);
    sha_pkg::out_item_t exp;
    if (pending_words.size() == 0) begin
      $display("%0t: unexpected digest beat %h", $time, got);
      errors++;
      return;
    end
    exp = pending_words.pop_front();
    if (got.digest_word !== exp.digest_word) begin
      $display("%0t: digest_word expected %h actual %h", $time, exp.digest_word,
               got.digest_word);
      errors++;
    end
    if (got.word_index !== exp.word_index) begin
      $display("%0t: word_index expected %0d actual %0d", $time, exp.word_index,
               got.word_index);
      errors++;
    end
    if (got.last_word !== exp.last_word) begin
      $display("%0t: last_word expected %b actual %b", $time, exp.last_word,
               got.last_word);
      errors++;
    end
    if (got.last_word === 1'b1) digests_seen++;
  endfunction
endclass

module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  sha_pkg::in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  sha_pkg::out_item_t out_data;

  digest_scoreboard board;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_cycles = 0;
  int beats_sent = 0;

  sha256_byte_stream_hasher_unit uut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_data(in_data), .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: pop at random, honor a counted hold-off
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) board.check_result(out_data);
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one beat, with random idle cycles before it; push stays high after it
  task automatic send_beat(logic [7:0] b, logic present, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{data_byte: b, byte_present: present, last_byte: last};
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_input(in_data);
    if (present || last) beats_sent++;
  endtask

  // Send a message of len bytes; pattern 0 random, 1 all zero, 2 all ones
  task automatic send_message(int len, int pattern, bit empty_end);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (pattern == 1) ? 8'h00 : (pattern == 2) ? 8'hff : 8'($urandom);
      // drop in an occasional idle beat that the block ignores
      if (pattern == 0 && $urandom_range(15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      send_beat(b, 1'b1, (i == len - 1) && !empty_end);
    end
    if (empty_end || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    in_push <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, two-block padding, extreme byte values
    send_message(0, 0, 1'b1);
    send_message(56, 2, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_message(1, 1, 1'b0);
    drain();

    // Hold off the receiver while messages pile up behind it
    hold_off_cycles = 600;
    send_message(2, 0, 1'b0);
    send_message(2, 0, 1'b0);
    send_message(1, 0, 1'b0);
    send_message(3, 0, 1'b0);
    drain();

    // Random messages across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 79 : 20) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 79 : 20) : 0;
      for (int m = 0; m < 3; m++) begin
        send_message($urandom_range(9, 1), 0, $urandom_range(1));
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    repeat (200) @(posedge clk);
    $display("Covered %0d input beats and %0d digests, incl. empty and two-block padding.",
             beats_sent, board.digests_seen);
    if (board.errors == 0 && board.pending_words.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_bq.sv
rtl/sha_back.sv
rtl/sha256_byte_stream_hasher_unit.sv
rtl/sha_checker.sv
bench/testbench.sv
